@@ design/assert_macros.svh @@
// Assertion macros used by the top level of the convex hull block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CH_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("assertion failed: condition must never hold");
`define CH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: implication in next cycle");
`else
`define CH_ASSERT_NEVER(lbl, clk, rstn, expr)
`define CH_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ design/chull_pkg.sv @@
// Package of the convex hull block: sizes, point type, helper functions and
// the command and status structs between controller and datapath. No dependencies.
`default_nettype none
package chull_pkg;
    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int MIN_HULL   = 3;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int L1_W       = DIFF_W + 1;

    typedef struct packed {
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } t_point;

    typedef enum logic [1:0] {
        ST_SEL_IN,
        ST_SEL_Q,
        ST_SEL_BEST,
        ST_SEL_T
    } t_st_sel;

    typedef enum logic [2:0] {
        TOP_HOLD,
        TOP_FIRST,
        TOP_PUSH,
        TOP_REPL,
        TOP_POP
    } t_top_op;

    typedef struct packed {
        logic             st_rd;
        logic [IDX_W-1:0] st_rd_addr;
        logic             st_wr;
        logic [IDX_W-1:0] st_wr_addr;
        t_st_sel          st_wr_sel;
        logic             ld_best;
        logic             ld_t;
        logic             ld_p;
        logic             cross_start;
        logic             cross_scan;
        logic             sk_wr;
        logic [IDX_W-1:0] sk_wr_addr;
        logic             sk_wr_from_p;
        logic             sk_rd;
        logic [IDX_W-1:0] sk_rd_addr;
        logic             ld_sec;
        t_top_op          top_op;
        logic             out_ld;
        logic             out_from_stack;
        logic             out_last;
        logic             out_ovf;
    } t_cmd;

    typedef struct packed {
        logic y_less;
        logic same_q_p;
        logic same_q_top;
        logic goes_first;
        logic cross_pos;
        logic cross_done;
        logic out_busy;
    } t_sts;

    function automatic logic signed [DIFF_W-1:0] f_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    endfunction

    function automatic logic [DIFF_W-1:0] f_abs(input logic signed [DIFF_W-1:0] d);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction
endpackage
`default_nettype wire

@@ design/chull_cross.sv @@
// Three-stage pipelined 2D cross product a1*b2 - a2*b1.
// Depends on chull_pkg for the operand and result widths.
`default_nettype none
module chull_cross (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic signed [chull_pkg::DIFF_W-1:0]  i_a1,
    input  wire logic signed [chull_pkg::DIFF_W-1:0]  i_a2,
    input  wire logic signed [chull_pkg::DIFF_W-1:0]  i_b1,
    input  wire logic signed [chull_pkg::DIFF_W-1:0]  i_b2,
    output logic                                      o_done,
    output logic signed [chull_pkg::CROSS_W-1:0]      o_cross
);
    import chull_pkg::*;

    logic [2:0]                r_vld;
    logic signed [DIFF_W-1:0]  r_a1, r_a2, r_b1, r_b2;
    logic signed [PROD_W-1:0]  r_p1, r_p2;
    logic signed [CROSS_W-1:0] r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a1 <= i_a1;
            r_a2 <= i_a2;
            r_b1 <= i_b1;
            r_b2 <= i_b2;
        end
        r_p1 <= r_a1 * r_b2;
        r_p2 <= r_a2 * r_b1;
        r_c  <= CROSS_W'(r_p1) - CROSS_W'(r_p2);
    end

    assign o_done  = r_vld[2];
    assign o_cross = r_c;
endmodule
`default_nettype wire

@@ design/chull_datapath.sv @@
// Datapath: point store and hull stack memories, stack top registers, sort
// comparison, cross product unit and output register. Depends on chull_pkg, chull_cross.
`default_nettype none
module chull_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire chull_pkg::t_cmd                 i_cmd,
    input  wire logic [chull_pkg::COORD_BITS-1:0] i_in_x,
    input  wire logic [chull_pkg::COORD_BITS-1:0] i_in_y,
    input  wire logic                            i_out_ready,
    output chull_pkg::t_sts                      o_sts,
    output logic                                 o_out_valid,
    output logic [chull_pkg::COORD_BITS-1:0]     o_hull_x,
    output logic [chull_pkg::COORD_BITS-1:0]     o_hull_y,
    output logic                                 o_hull_last,
    output logic                                 o_ovf
);
    import chull_pkg::*;

    t_point r_store [MAX_POINTS];
    t_point r_stack [MAX_POINTS];
    t_point r_q, r_skq, r_best, r_t, r_p, r_top, r_sec;
    t_point w_st_wdata, w_sk_wdata;

    logic                      r_ovalid, r_olast, r_oovf;
    t_point                    r_opt;

    logic signed [DIFF_W-1:0]  w_ax, w_ay, w_bx, w_by;
    logic signed [DIFF_W-1:0]  w_a1, w_a2, w_b1, w_b2;
    logic                      w_done;
    logic signed [CROSS_W-1:0] w_cross;
    logic                      w_ha, w_hb;
    logic [L1_W-1:0]           w_l1a, w_l1b;

    always_comb begin
        case (i_cmd.st_wr_sel)
            ST_SEL_IN:   w_st_wdata = '{y: i_in_y, x: i_in_x};
            ST_SEL_Q:    w_st_wdata = r_q;
            ST_SEL_BEST: w_st_wdata = r_best;
            ST_SEL_T:    w_st_wdata = r_t;
            default:     w_st_wdata = r_q;
        endcase
    end
    assign w_sk_wdata = i_cmd.sk_wr_from_p ? r_p : r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.st_wr) begin
            r_store[i_cmd.st_wr_addr] <= w_st_wdata;
        end
        if (i_cmd.st_rd) begin
            r_q <= r_store[i_cmd.st_rd_addr];
        end
        if (i_cmd.sk_wr) begin
            r_stack[i_cmd.sk_wr_addr] <= w_sk_wdata;
        end
        if (i_cmd.sk_rd) begin
            r_skq <= r_stack[i_cmd.sk_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_best) r_best <= r_q;
        if (i_cmd.ld_t)    r_t    <= r_q;
        if (i_cmd.ld_p)    r_p    <= r_q;
        if (i_cmd.ld_sec)  r_sec  <= r_skq;
        case (i_cmd.top_op)
            TOP_FIRST: begin
                r_sec <= r_p;
                r_top <= r_q;
            end
            TOP_PUSH: begin
                r_sec <= r_top;
                r_top <= r_q;
            end
            TOP_REPL: r_top <= r_q;
            TOP_POP:  r_top <= r_sec;
            default:  ;
        endcase
    end

    // Angle sort operands are taken about the bottom point, held in r_best.
    assign w_ax = f_diff(r_t.x, r_best.x);
    assign w_ay = f_diff(r_t.y, r_best.y);
    assign w_bx = f_diff(r_q.x, r_best.x);
    assign w_by = f_diff(r_q.y, r_best.y);

    assign w_a1 = i_cmd.cross_scan ? f_diff(r_top.x, r_sec.x) : w_ax;
    assign w_a2 = i_cmd.cross_scan ? f_diff(r_top.y, r_sec.y) : w_ay;
    assign w_b1 = i_cmd.cross_scan ? f_diff(r_q.x, r_top.x)   : w_bx;
    assign w_b2 = i_cmd.cross_scan ? f_diff(r_q.y, r_top.y)   : w_by;

    chull_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.cross_start),
        .i_a1    (w_a1),
        .i_a2    (w_a2),
        .i_b1    (w_b1),
        .i_b2    (w_b2),
        .o_done  (w_done),
        .o_cross (w_cross)
    );

    // Points on one ray from the bottom point order by distance exactly as
    // they order by the sum of absolute offsets.
    assign w_ha  = (w_ay == '0) && w_ax[DIFF_W-1];
    assign w_hb  = (w_by == '0) && w_bx[DIFF_W-1];
    assign w_l1a = L1_W'(f_abs(w_ax)) + L1_W'(f_abs(w_ay));
    assign w_l1b = L1_W'(f_abs(w_bx)) + L1_W'(f_abs(w_by));

    always_comb begin
        o_sts.y_less     = $signed(r_q.y) < $signed(r_best.y);
        o_sts.same_q_p   = (r_q == r_p);
        o_sts.same_q_top = (r_q == r_top);
        o_sts.cross_pos  = !w_cross[CROSS_W-1] && (w_cross != '0);
        o_sts.cross_done = w_done;
        o_sts.out_busy   = r_ovalid;
        if (w_ha != w_hb) begin
            o_sts.goes_first = w_hb;
        end else if (!w_ha && (w_cross != '0)) begin
            o_sts.goes_first = !w_cross[CROSS_W-1];
        end else begin
            o_sts.goes_first = w_l1a < w_l1b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_opt   <= i_cmd.out_from_stack ? r_skq : r_q;
            r_olast <= i_cmd.out_last;
            r_oovf  <= i_cmd.out_ovf;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_hull_x    = r_opt.x;
    assign o_hull_y    = r_opt.y;
    assign o_hull_last = r_olast;
    assign o_ovf       = r_oovf;
endmodule
`default_nettype wire

@@ design/chull_ctrl.sv @@
// Controller: sequences loading, bottom search, swap, insertion sort,
// duplicate skip, stack scan and output. Depends on chull_pkg.
`default_nettype none
module chull_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_last,
    output logic                 o_in_ready,
    input  wire chull_pkg::t_sts i_sts,
    output chull_pkg::t_cmd      o_cmd
);
    import chull_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MIN_RD, S_MIN_CMP,
        S_SW_RD, S_SW_W1, S_SW_W0,
        S_IS_RD, S_IS_T, S_IS_JRD, S_IS_X, S_IS_WAIT, S_IS_PUT,
        S_DD_RD0, S_DD_RD1, S_DD_CMP, S_DD_PUSH1,
        S_SC_RD, S_SC_V, S_SC_WAIT, S_SC_POP,
        S_OUT_RD, S_OUT_LD
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt, r_n, n_n, r_i, n_i, r_j, n_j;
    logic [CNT_W-1:0] r_depth, n_depth, r_k, n_k, r_outn, n_outn;
    logic [IDX_W-1:0] r_b, n_b;
    logic             r_ovf, n_ovf, r_src, n_src;
    logic [CNT_W-1:0] w_inc, w_ip1, w_jm1, w_dm3, w_nm1;
    logic             w_acc;

    assign w_acc = i_in_valid && (r_state == S_IDLE);
    assign w_inc = (r_cnt < CNT_W'(MAX_POINTS)) ? r_cnt + CNT_W'(1) : r_cnt;
    assign w_ip1 = r_i + CNT_W'(1);
    assign w_jm1 = r_j - CNT_W'(1);
    assign w_dm3 = r_depth - CNT_W'(MIN_HULL);
    assign w_nm1 = r_n - CNT_W'(1);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_i     = r_i;
        n_j     = r_j;
        n_depth = r_depth;
        n_k     = r_k;
        n_outn  = r_outn;
        n_b     = r_b;
        n_ovf   = r_ovf;
        n_src   = r_src;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (r_cnt < CNT_W'(MAX_POINTS)) begin
                        o_cmd.st_wr      = 1'b1;
                        o_cmd.st_wr_addr = r_cnt[IDX_W-1:0];
                        o_cmd.st_wr_sel  = ST_SEL_IN;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_cnt = w_inc;
                    if (i_in_last) begin
                        n_cnt = '0;
                        n_n   = w_inc;
                        n_i   = '0;
                        n_k   = '0;
                        if (w_inc < CNT_W'(MIN_HULL)) begin
                            n_src   = 1'b0;
                            n_outn  = w_inc;
                            n_state = S_OUT_RD;
                        end else begin
                            n_state = S_MIN_RD;
                        end
                    end
                end
            end
            S_MIN_RD: begin
                o_cmd.st_rd      = 1'b1;
                o_cmd.st_rd_addr = r_i[IDX_W-1:0];
                n_state          = S_MIN_CMP;
            end
            S_MIN_CMP: begin
                if ((r_i == '0) || i_sts.y_less) begin
                    o_cmd.ld_best = 1'b1;
                    n_b           = r_i[IDX_W-1:0];
                end
                if (r_i == w_nm1) begin
                    n_state = S_SW_RD;
                end else begin
                    n_i     = w_ip1;
                    n_state = S_MIN_RD;
                end
            end
            S_SW_RD: begin
                o_cmd.st_rd      = 1'b1;
                o_cmd.st_rd_addr = '0;
                n_state          = S_SW_W1;
            end
            S_SW_W1: begin
                o_cmd.st_wr      = 1'b1;
                o_cmd.st_wr_addr = r_b;
                o_cmd.st_wr_sel  = ST_SEL_Q;
                n_state          = S_SW_W0;
            end
            S_SW_W0: begin
                o_cmd.st_wr      = 1'b1;
                o_cmd.st_wr_addr = '0;
                o_cmd.st_wr_sel  = ST_SEL_BEST;
                n_i              = CNT_W'(2);
                n_state          = S_IS_RD;
            end
            S_IS_RD: begin
                o_cmd.st_rd      = 1'b1;
                o_cmd.st_rd_addr = r_i[IDX_W-1:0];
                n_state          = S_IS_T;
            end
            S_IS_T: begin
                o_cmd.ld_t = 1'b1;
                n_j        = r_i;
                n_state    = S_IS_JRD;
            end
            S_IS_JRD: begin
                if (r_j > CNT_W'(1)) begin
                    o_cmd.st_rd      = 1'b1;
                    o_cmd.st_rd_addr = w_jm1[IDX_W-1:0];
                    n_state          = S_IS_X;
                end else begin
                    n_state = S_IS_PUT;
                end
            end
            S_IS_X: begin
                o_cmd.cross_start = 1'b1;
                n_state           = S_IS_WAIT;
            end
            S_IS_WAIT: begin
                if (i_sts.cross_done) begin
                    if (i_sts.goes_first) begin
                        o_cmd.st_wr      = 1'b1;
                        o_cmd.st_wr_addr = r_j[IDX_W-1:0];
                        o_cmd.st_wr_sel  = ST_SEL_Q;
                        n_j              = w_jm1;
                        n_state          = S_IS_JRD;
                    end else begin
                        n_state = S_IS_PUT;
                    end
                end
            end
            S_IS_PUT: begin
                o_cmd.st_wr      = 1'b1;
                o_cmd.st_wr_addr = r_j[IDX_W-1:0];
                o_cmd.st_wr_sel  = ST_SEL_T;
                if (r_i == w_nm1) begin
                    n_i     = '0;
                    n_state = S_DD_RD0;
                end else begin
                    n_i     = w_ip1;
                    n_state = S_IS_RD;
                end
            end
            S_DD_RD0: begin
                o_cmd.st_rd      = 1'b1;
                o_cmd.st_rd_addr = r_i[IDX_W-1:0];
                n_state          = S_DD_RD1;
            end
            S_DD_RD1: begin
                // The comparison partner wraps to the first point.
                o_cmd.ld_p       = 1'b1;
                o_cmd.st_rd      = 1'b1;
                o_cmd.st_rd_addr = (w_ip1 == r_n) ? '0 : w_ip1[IDX_W-1:0];
                n_state          = S_DD_CMP;
            end
            S_DD_CMP: begin
                if (i_sts.same_q_p) begin
                    if (r_i == w_nm1) begin
                        o_cmd.sk_wr        = 1'b1;
                        o_cmd.sk_wr_addr   = '0;
                        o_cmd.sk_wr_from_p = 1'b1;
                        n_depth            = CNT_W'(1);
                        n_src              = 1'b1;
                        n_outn             = CNT_W'(1);
                        n_k                = '0;
                        n_state            = S_OUT_RD;
                    end else begin
                        n_i     = w_ip1;
                        n_state = S_DD_RD0;
                    end
                end else begin
                    o_cmd.sk_wr        = 1'b1;
                    o_cmd.sk_wr_addr   = '0;
                    o_cmd.sk_wr_from_p = 1'b1;
                    o_cmd.top_op       = TOP_FIRST;
                    n_state            = S_DD_PUSH1;
                end
            end
            S_DD_PUSH1: begin
                o_cmd.sk_wr      = 1'b1;
                o_cmd.sk_wr_addr = IDX_W'(1);
                n_depth          = CNT_W'(2);
                n_i              = r_i + CNT_W'(2);
                n_state          = S_SC_RD;
            end
            S_SC_RD: begin
                if (r_i >= r_n) begin
                    n_src   = 1'b1;
                    n_outn  = r_depth;
                    n_k     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    o_cmd.st_rd      = 1'b1;
                    o_cmd.st_rd_addr = r_i[IDX_W-1:0];
                    n_state          = S_SC_V;
                end
            end
            S_SC_V: begin
                if (i_sts.same_q_top) begin
                    n_i     = w_ip1;
                    n_state = S_SC_RD;
                end else begin
                    o_cmd.cross_start = 1'b1;
                    o_cmd.cross_scan  = 1'b1;
                    n_state           = S_SC_WAIT;
                end
            end
            S_SC_WAIT: begin
                if (i_sts.cross_done) begin
                    if (!i_sts.cross_pos) begin
                        if (r_depth >= CNT_W'(MIN_HULL)) begin
                            o_cmd.top_op     = TOP_POP;
                            o_cmd.sk_rd      = 1'b1;
                            o_cmd.sk_rd_addr = w_dm3[IDX_W-1:0];
                            n_depth          = r_depth - CNT_W'(1);
                            n_state          = S_SC_POP;
                        end else begin
                            // Only two on the stack: the top gives way to the new point.
                            o_cmd.top_op     = TOP_REPL;
                            o_cmd.sk_wr      = 1'b1;
                            o_cmd.sk_wr_addr = IDX_W'(1);
                            n_i              = w_ip1;
                            n_state          = S_SC_RD;
                        end
                    end else begin
                        if (r_depth < CNT_W'(MAX_POINTS)) begin
                            o_cmd.top_op     = TOP_PUSH;
                            o_cmd.sk_wr      = 1'b1;
                            o_cmd.sk_wr_addr = r_depth[IDX_W-1:0];
                            n_depth          = r_depth + CNT_W'(1);
                        end
                        n_i     = w_ip1;
                        n_state = S_SC_RD;
                    end
                end
            end
            S_SC_POP: begin
                o_cmd.ld_sec = 1'b1;
                n_state      = S_SC_V;
            end
            S_OUT_RD: begin
                if (!i_sts.out_busy) begin
                    o_cmd.st_rd      = !r_src;
                    o_cmd.st_rd_addr = r_k[IDX_W-1:0];
                    o_cmd.sk_rd      = r_src;
                    o_cmd.sk_rd_addr = r_k[IDX_W-1:0];
                    n_state          = S_OUT_LD;
                end
            end
            S_OUT_LD: begin
                o_cmd.out_ld         = 1'b1;
                o_cmd.out_from_stack = r_src;
                o_cmd.out_last       = (r_k == r_outn - CNT_W'(1));
                o_cmd.out_ovf        = r_ovf;
                if (r_k == r_outn - CNT_W'(1)) begin
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + CNT_W'(1);
                    n_state = S_OUT_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_depth <= '0;
            r_k     <= '0;
            r_outn  <= '0;
            r_b     <= '0;
            r_ovf   <= 1'b0;
            r_src   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
            r_depth <= n_depth;
            r_k     <= n_k;
            r_outn  <= n_outn;
            r_b     <= n_b;
            r_ovf   <= n_ovf;
            r_src   <= n_src;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule
`default_nettype wire

@@ design/convex_hull_graham_scan.sv @@
// Top level of the convex hull block: controller plus datapath.
// Depends on chull_pkg, chull_ctrl, chull_datapath and assert_macros.svh.
//
//  channel  direction  word contents
//  s_axis   in         point_x, point_y; tlast = point_last
//  m_axis   out        hull_x, hull_y; tlast = hull_last; tuser = overflowed
//
// Points load at one word per cycle. After the last word the block searches
// the bottom point, sorts by insertion with the cross product unit, scans the
// stack and sends each vertex, which output stalls can hold back.
// The input is not ready from the last word until the last vertex is loaded.
// Reset is synchronous, active low, and clears all control state.
`default_nettype none
module convex_hull_graham_scan (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] point_x, [31:16] point_y
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [15:0] hull_x, [31:16] hull_y
    output logic             m_axis_tlast,
    output logic             m_axis_tuser    // [0] overflowed
);
    import chull_pkg::*;
    `include "assert_macros.svh"

    t_cmd                  w_cmd;
    t_sts                  w_sts;
    logic [COORD_BITS-1:0] w_hx, w_hy;

    chull_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    chull_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_x      (s_axis_tdata[COORD_BITS-1:0]),
        .i_in_y      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_out_ready (m_axis_tready),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .o_hull_x    (w_hx),
        .o_hull_y    (w_hy),
        .o_hull_last (m_axis_tlast),
        .o_ovf       (m_axis_tuser)
    );

    assign m_axis_tdata = {w_hy, w_hx};

    `CH_ASSERT_NEVER(a_idle_no_cross, i_clk, i_rst_n, s_axis_tready && w_cmd.cross_start)
    `CH_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_ld && w_sts.out_busy)
    `CH_ASSERT_NEVER(a_one_store_wr, i_clk, i_rst_n, w_cmd.st_wr && w_cmd.out_ld)
    `CH_ASSERT_NEXT(a_cross_spaced, i_clk, i_rst_n, w_cmd.cross_start, !w_cmd.cross_start)
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking bench for the convex hull block: streams point sets in and
// checks every hull vertex against a built-in Graham scan predictor.
// Depends on chull_pkg and convex_hull_graham_scan.
module tb_top;
    import chull_pkg::*;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
        logic        ovf;
    } t_vertex;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [15:0] point_x, [31:16] point_y
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [15:0] hull_x, [31:16] hull_y
    logic        m_axis_tlast;
    logic        m_axis_tuser;   // [0] overflowed

    convex_hull_graham_scan DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    // Predictor state: the current set of points.
    longint  set_x[$];
    longint  set_y[$];
    bit      set_ovf;
    t_vertex hull_q[$];

    int      n_errors;
    int      n_points;
    int      n_vertices;
    int      n_sets;
    bit      quiet;       // no idling in the final part
    bit      hold_off;    // receiver stall for the pressure test

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit ahead_of(longint px, longint py, longint qx, longint qy,
                                    longint ox, longint oy);
        longint ax, ay, bx, by, c;
        bit ha, hb;
        ax = px - ox; ay = py - oy; bx = qx - ox; by = qy - oy;
        ha = (ay == 0 && ax < 0);
        hb = (by == 0 && bx < 0);
        if (ha != hb) return ha < hb;
        if (!ha) begin
            c = ax * by - ay * bx;
            if (c > 0) return 1;
            if (c < 0) return 0;
        end
        return ax * ax + ay * ay < bx * bx + by * by;
    endfunction

    // Computes the hull of the stored set and queues the expected vertices.
    task automatic predict_hull();
        longint px[$], py[$], sx[$], sy[$];
        longint tx, ty, c;
        int n, b, i, j;
        px = set_x; py = set_y; n = px.size();
        if (n >= MIN_HULL) begin
            b = 0;
            for (i = 1; i < n; i++) if (py[i] < py[b]) b = i;
            tx = px[0]; ty = py[0]; px[0] = px[b]; py[0] = py[b]; px[b] = tx; py[b] = ty;
            for (i = 2; i < n; i++) begin
                tx = px[i]; ty = py[i]; j = i;
                while (j > 1 && ahead_of(tx, ty, px[j-1], py[j-1], px[0], py[0])) begin
                    px[j] = px[j-1]; py[j] = py[j-1]; j--;
                end
                px[j] = tx; py[j] = ty;
            end
            i = 0;
            while (i < n && px[i] == px[(i+1)%n] && py[i] == py[(i+1)%n]) i++;
            if (i >= n) begin
                sx.insert(sx.size(), px[0]); sy.insert(sy.size(), py[0]);
            end else begin
                sx.insert(sx.size(), px[i]); sy.insert(sy.size(), py[i]);
                sx.insert(sx.size(), px[i+1]); sy.insert(sy.size(), py[i+1]);
                i += 2;
                while (i < n) begin
                    if (px[i] == sx[$] && py[i] == sy[$]) begin
                        i++;
                        continue;
                    end
                    c = (sx[$] - sx[$-1]) * (py[i] - sy[$])
                      - (sy[$] - sy[$-1]) * (px[i] - sx[$]);
                    if (c <= 0) begin
                        if (sx.size() >= 3) begin
                            sx.delete(sx.size() - 1); sy.delete(sy.size() - 1);
                        end else begin
                            sx[$] = px[i]; sy[$] = py[i]; i++;
                        end
                    end else begin
                        sx.insert(sx.size(), px[i]); sy.insert(sy.size(), py[i]); i++;
                    end
                end
            end
        end else begin
            sx = px; sy = py;
        end
        for (i = 0; i < sx.size(); i++)
            hull_q.insert(hull_q.size(), '{x: sx[i][15:0], y: sy[i][15:0],
                                           last: (i == sx.size() - 1), ovf: set_ovf});
        set_x.delete(); set_y.delete(); set_ovf = 0;
    endtask

    task automatic random_gap();
        int k;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            for (k = $urandom_range(1, 9); k > 0; k--) @(posedge i_clk);
        end
    endtask

    // Sends one point word and updates the predictor once it is accepted.
    task automatic send_point(logic [15:0] x, logic [15:0] y, bit last);
        random_gap();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        n_points++;
        if (set_x.size() < MAX_POINTS) begin
            set_x.insert(set_x.size(), longint'($signed(x)));
            set_y.insert(set_y.size(), longint'($signed(y)));
        end else begin
            set_ovf = 1;
        end
        if (last) begin
            predict_hull();
            n_sets++;
        end
    endtask

    task automatic send_set(int n, int span);
        int i;
        logic [15:0] x, y;
        for (i = 0; i < n; i++) begin
            if (span == 0) begin
                x = 16'($urandom); y = 16'($urandom);
            end else begin
                x = 16'($urandom_range(0, 2 * span) - span);
                y = 16'($urandom_range(0, 2 * span) - span);
            end
            send_point(x, y, i == n - 1);
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (hull_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic test_directed();
        // A single point and two points are echoed in arrival order.
        send_point(16'h8000, 16'h7fff, 1);
        send_point(16'h7fff, 16'h8000, 0);
        send_point(16'h8000, 16'h8000, 1);
        // Square with extreme corners, an interior point and a copy of the bottom.
        send_point(16'h7fff, 16'h7fff, 0);
        send_point(16'h8000, 16'h8000, 0);
        send_point(16'h0000, 16'h0000, 0);
        send_point(16'h8000, 16'h7fff, 0);
        send_point(16'h8000, 16'h8000, 0);
        send_point(16'h7fff, 16'h8000, 1);
        // All points identical.
        repeat (3) send_point(16'h0005, 16'hfffb, 0);
        send_point(16'h0005, 16'hfffb, 1);
        // Collinear points, with a repeated one; ties on the lowest row.
        send_point(16'd3, 16'd3, 0);
        send_point(16'd1, 16'd1, 0);
        send_point(16'd2, 16'd2, 0);
        send_point(16'd2, 16'd2, 0);
        send_point(16'd0, 16'd0, 0);
        send_point(16'hfffe, 16'd0, 1);
        wait_drain();
    endtask

    task automatic test_overflow();
        // A full store, then a dropped last point still closes the set.
        send_set(MAX_POINTS + 1, 100);
        send_set(MAX_POINTS + 3, 0);
        wait_drain();
    endtask

    task automatic test_backpressure();
        int i;
        hold_off = 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            for (i = 0; i < 4; i++) send_set($urandom_range(3, 8), 50);
        join
        wait_drain();
    endtask

    task automatic test_random();
        int total;
        total = n_points;
        while (total < 355) begin
            case ($urandom_range(0, 5))
                0: send_set($urandom_range(1, 2), 0);
                1: send_set($urandom_range(3, 12), 3);
                2: send_set($urandom_range(3, 20), 0);
                default: send_set($urandom_range(3, 16), 1000);
            endcase
            total = n_points;
            if (total > 300) quiet = 1;
        end
        wait_drain();
    endtask

    // Receiver: random stalls and a field-by-field compare of each vertex.
    always @(posedge i_clk) begin
        t_vertex want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_vertices++;
            if (hull_q.size() == 0) begin
                $display("%0t: unexpected vertex %h last %b ovf %b", $time,
                         m_axis_tdata, m_axis_tlast, m_axis_tuser);
                n_errors++;
            end else begin
                want = hull_q.pop_front();
                if (m_axis_tdata !== {want.y, want.x} || m_axis_tlast !== want.last
                    || m_axis_tuser !== want.ovf) begin
                    $display("%0t: expected %h last %b ovf %b, got %h last %b ovf %b",
                             $time, {want.y, want.x}, want.last, want.ovf,
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        int stall;
        m_axis_tready = 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 9);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        n_errors = 0; n_points = 0; n_vertices = 0; n_sets = 0;
        quiet = 0; hold_off = 0; set_ovf = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_backpressure();
        test_random();
        $display("Covered %0d points in %0d sets, %0d hull vertices checked.",
                 n_points, n_sets, n_vertices);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
